// ===== hw/rtl/rocc_pkg.sv =====
// Shared types and constants for the room occupancy and climate controller.
package rocc_pkg;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_FAIL_LIMIT      = 3'd0;
   localparam logic [2:0] REG_OCC_DISTANCE    = 3'd1;
   localparam logic [2:0] REG_VACANCY_TIMEOUT = 3'd2;
   localparam logic [2:0] REG_ALERT_ON_TEMP   = 3'd3;
   localparam logic [2:0] REG_ALERT_OFF_TEMP  = 3'd4;
   localparam logic [2:0] REG_OP_MODE         = 3'd5;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   // Operating modes.
   localparam logic [1:0] MODE_AUTO   = 2'd0;
   localparam logic [1:0] MODE_MANUAL = 2'd1;
   localparam logic [1:0] MODE_AWAY   = 2'd2;

   // Node states reported with each result.
   localparam logic [1:0] NODE_MONITORING = 2'd0;
   localparam logic [1:0] NODE_MANUAL     = 2'd1;
   localparam logic [1:0] NODE_ALERT      = 2'd2;
   localparam logic [1:0] NODE_FAULT      = 2'd3;

   // Fault code bits.
   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_CLIMATE = 2'd1;
   localparam logic [1:0] FAULT_RANGE   = 2'd2;

   // Register reset values.
   localparam logic [7:0]         RST_FAIL_LIMIT      = 8'd5;
   localparam logic [9:0]         RST_OCC_DISTANCE    = 10'd100;
   localparam logic [31:0]        RST_VACANCY_TIMEOUT = 32'd30000;
   localparam logic signed [11:0] RST_ALERT_ON_TEMP   = 12'sd300;
   localparam logic signed [11:0] RST_ALERT_OFF_TEMP  = 12'sd280;

   localparam logic [7:0] FAIL_COUNT_MAX = 8'hFF;

   // One sensor poll.
   typedef struct packed {
      logic               climate_ok;
      logic signed [11:0] temperature;
      logic               range_ok;
      logic [9:0]         distance_cm;
      logic               is_dark;
      logic [31:0]        now_ms;
      logic               manual_light;
      logic               manual_aux;
   } req_word_type;

   // One controller result.
   typedef struct packed {
      logic        instant_occupied;
      logic        sensor_fault;
      logic [1:0]  fault_code;
      logic        occupied;
      logic        temp_alert;
      logic [1:0]  node_state;
      logic        light_relay;
      logic        aux_relay;
      logic [31:0] stamp_ms;
   } rsp_word_type;

endpackage

// ===== hw/rtl/room_occupancy_climate_controller_core.sv =====
// Top level of the room occupancy and climate controller.
//
// Each request word is one sensor poll and yields exactly one response word. The block
// is a two-register pipeline: a poll is captured in an input register, then one short
// pass of logic (saturating failure counters, a 32-bit wrapping time difference against
// the vacancy timeout, signed threshold compares for the alert latch, and the mode
// decode) updates the state and loads the result register. While the output is not
// stalled, a poll can be accepted on every clock, so the sustained rate is one word per
// cycle; a stall holds the word in the input register. A result word stays offered on
// the response side until it is taken. The configuration registers take effect for the
// next poll that reaches the compute pass.
module room_occupancy_climate_controller_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  rocc_pkg::req_word_type                 req_word,
   // Response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output rocc_pkg::rsp_word_type                 rsp_word,
   // Configuration port
   input  logic                                   csr_we,
   input  logic [rocc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [rocc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   // Configuration registers.
   logic [7:0]         fail_limit_ff;
   logic [9:0]         occ_distance_ff;
   logic [31:0]        vacancy_timeout_ff;
   logic signed [11:0] alert_on_ff;
   logic signed [11:0] alert_off_ff;
   logic [1:0]         op_mode_ff;

   // Controller state.
   logic [7:0]  climate_fail_ff, climate_fail_in;
   logic [7:0]  range_fail_ff, range_fail_in;
   logic [31:0] last_seen_ff, last_seen_in;
   logic        ever_seen_ff, ever_seen_in;
   logic        alert_latch_ff, alert_latch_in;

   // Pipeline registers.
   logic                   in_valid_ff;
   rocc_pkg::req_word_type in_word_ff;
   logic                   out_valid_ff;
   rocc_pkg::rsp_word_type out_word_ff, out_word_in;

   logic advance;

   // Handshake: the input stage moves on when the result register is empty or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         fail_limit_ff      <= rocc_pkg::RST_FAIL_LIMIT;
         occ_distance_ff    <= rocc_pkg::RST_OCC_DISTANCE;
         vacancy_timeout_ff <= rocc_pkg::RST_VACANCY_TIMEOUT;
         alert_on_ff        <= rocc_pkg::RST_ALERT_ON_TEMP;
         alert_off_ff       <= rocc_pkg::RST_ALERT_OFF_TEMP;
         op_mode_ff         <= rocc_pkg::MODE_AUTO;
      end else if (csr_we) begin
         unique case (csr_index)
            rocc_pkg::REG_FAIL_LIMIT:      fail_limit_ff      <= csr_wdata[7:0];
            rocc_pkg::REG_OCC_DISTANCE:    occ_distance_ff    <= csr_wdata[9:0];
            rocc_pkg::REG_VACANCY_TIMEOUT: vacancy_timeout_ff <= csr_wdata[31:0];
            rocc_pkg::REG_ALERT_ON_TEMP:   alert_on_ff        <= signed'(csr_wdata[11:0]);
            rocc_pkg::REG_ALERT_OFF_TEMP:  alert_off_ff       <= signed'(csr_wdata[11:0]);
            rocc_pkg::REG_OP_MODE:         op_mode_ff         <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Compute pass: state update and result for the word in the input register.
   always_comb begin
      logic [1:0]  code;
      logic        instant;
      logic        held;
      logic [31:0] elapsed;
      logic        fault;

      // Consecutive-failure counters, saturating at their maximum.
      if (in_word_ff.climate_ok) begin
         climate_fail_in = '0;
      end else if (climate_fail_ff == rocc_pkg::FAIL_COUNT_MAX) begin
         climate_fail_in = climate_fail_ff;
      end else begin
         climate_fail_in = climate_fail_ff + 8'd1;
      end
      if (in_word_ff.range_ok) begin
         range_fail_in = '0;
      end else if (range_fail_ff == rocc_pkg::FAIL_COUNT_MAX) begin
         range_fail_in = range_fail_ff;
      end else begin
         range_fail_in = range_fail_ff + 8'd1;
      end

      code = rocc_pkg::FAULT_NONE;
      if (climate_fail_in >= fail_limit_ff) begin
         code = code | rocc_pkg::FAULT_CLIMATE;
      end
      if (range_fail_in >= fail_limit_ff) begin
         code = code | rocc_pkg::FAULT_RANGE;
      end
      fault = (code != rocc_pkg::FAULT_NONE);

      // Occupancy: a near sighting restamps, otherwise hold until the timeout runs out.
      instant = in_word_ff.range_ok && (in_word_ff.distance_cm != 10'd0) &&
                (in_word_ff.distance_cm <= occ_distance_ff);
      elapsed = in_word_ff.now_ms - last_seen_ff;
      held    = instant || (ever_seen_ff && (elapsed < vacancy_timeout_ff));
      last_seen_in = instant ? in_word_ff.now_ms : last_seen_ff;
      ever_seen_in = ever_seen_ff || instant;

      // High-temperature latch with hysteresis; set wins over clear.
      alert_latch_in = alert_latch_ff;
      if (in_word_ff.climate_ok) begin
         if (in_word_ff.temperature >= alert_on_ff) begin
            alert_latch_in = 1'b1;
         end else if (in_word_ff.temperature <= alert_off_ff) begin
            alert_latch_in = 1'b0;
         end
      end

      // Node state and relays by fault status and mode.
      out_word_in.instant_occupied = instant;
      out_word_in.sensor_fault     = fault;
      out_word_in.fault_code       = code;
      out_word_in.occupied         = held;
      out_word_in.temp_alert       = alert_latch_in;
      out_word_in.stamp_ms         = in_word_ff.now_ms;
      if (fault) begin
         out_word_in.node_state  = rocc_pkg::NODE_FAULT;
         out_word_in.light_relay = 1'b0;
         out_word_in.aux_relay   = 1'b0;
      end else if (op_mode_ff == rocc_pkg::MODE_MANUAL) begin
         out_word_in.node_state  = rocc_pkg::NODE_MANUAL;
         out_word_in.light_relay = in_word_ff.manual_light;
         out_word_in.aux_relay   = in_word_ff.manual_aux;
      end else if (op_mode_ff == rocc_pkg::MODE_AWAY) begin
         out_word_in.node_state  = instant ? rocc_pkg::NODE_ALERT : rocc_pkg::NODE_MONITORING;
         out_word_in.light_relay = 1'b0;
         out_word_in.aux_relay   = instant;
      end else begin
         // Auto mode; the unused mode code behaves the same.
         out_word_in.node_state  = alert_latch_in ? rocc_pkg::NODE_ALERT
                                                  : rocc_pkg::NODE_MONITORING;
         out_word_in.light_relay = in_word_ff.is_dark && held;
         out_word_in.aux_relay   = alert_latch_in;
      end
   end

   // State registers advance once per word leaving the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         climate_fail_ff <= '0;
         range_fail_ff   <= '0;
         last_seen_ff    <= '0;
         ever_seen_ff    <= 1'b0;
         alert_latch_ff  <= 1'b0;
      end else if (advance) begin
         climate_fail_ff <= climate_fail_in;
         range_fail_ff   <= range_fail_in;
         last_seen_ff    <= last_seen_in;
         ever_seen_ff    <= ever_seen_in;
         alert_latch_ff  <= alert_latch_in;
      end
   end

   // Pipeline valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule

// ===== hw/rtl/rocc_checker.sv =====
// Port-level checks for the room occupancy and climate controller, bound to the top level.
module rocc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rocc_pkg::rsp_word_type rsp_word
);

   // A response word stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before it was taken");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response offered after reset");

   // Any fault forces the fault state with both relays off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.fault_code != rocc_pkg::FAULT_NONE) |->
         rsp_word.sensor_fault && (rsp_word.node_state == rocc_pkg::NODE_FAULT) &&
         !rsp_word.light_relay && !rsp_word.aux_relay)
      else $error("fault not reflected in node state or relays");

   // Outside manual override the light is only driven while the room is held occupied.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.light_relay &&
         (rsp_word.node_state != rocc_pkg::NODE_MANUAL) |-> rsp_word.occupied)
      else $error("light relay on in an unoccupied room");

endmodule

bind room_occupancy_climate_controller_core rocc_checker u_rocc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

// ===== sim/room_occupancy_climate_controller_core_tb.sv =====
// Self-checking testbench for the room occupancy and climate controller core.
`timescale 1ns / 100ps

module room_occupancy_climate_controller_core_tb;

   // The unused fourth mode value, which the block treats as auto.
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // Register widths, used to fill the unused upper bits of a write with noise.
   localparam int FAIL_LIMIT_BITS = 8;
   localparam int DISTANCE_BITS   = 10;
   localparam int TIMEOUT_BITS    = 32;
   localparam int TEMP_BITS       = 12;
   localparam int MODE_BITS       = 2;

   // One row of the scripted opening sequence.
   typedef struct {
      logic [1:0]             mode;
      rocc_pkg::req_word_type poll;
      bit                     typed;
      rocc_pkg::rsp_word_type result;
   } script_row_type;

   // Register settings and stimulus shape for one random phase.
   typedef struct {
      logic [7:0]         fail_limit;
      logic [9:0]         near_cm;
      logic [31:0]        hold_ms;
      logic signed [11:0] hot_on;
      logic signed [11:0] hot_off;
      logic [1:0]         mode;
      int                 polls;
      int                 climate_bad_pct;
      int                 range_bad_pct;
      int                 step_max;
   } phase_plan_type;

   logic                                        clock;
   logic                                        reset;
   logic                                        req_valid;
   logic                                        req_ready;
   rocc_pkg::req_word_type                      req_word;
   logic                                        rsp_valid;
   logic                                        rsp_ready;
   rocc_pkg::rsp_word_type                      rsp_word;
   logic                                        csr_we;
   logic [rocc_pkg::CSR_INDEX_WIDTH-1:0]        csr_index;
   logic [rocc_pkg::CSR_DATA_WIDTH-1:0]         csr_wdata;

   // Controller settings as the predictor sees them.
   logic [7:0]         cfg_fail_limit;
   logic [9:0]         cfg_near_cm;
   logic [31:0]        cfg_hold_ms;
   logic signed [11:0] cfg_hot_on;
   logic signed [11:0] cfg_hot_off;
   logic [1:0]         cfg_mode;

   // Controller state as the predictor sees it.
   logic [7:0]  climate_fails;
   logic [7:0]  range_fails;
   logic [31:0] last_sighting_ms;
   logic        sighted;
   logic        hot_latch;

   rocc_pkg::rsp_word_type pending_results[$];
   script_row_type         script[$];
   phase_plan_type         plans[$];

   int          temp_extremes[4] = '{-2048, 2047, -400, 1250};
   logic [31:0] clock_ms;
   bit          sender_calm;
   bit          ready_calm;
   int          ready_hold;
   int          mismatches;
   int          polls_sent;
   int          results_seen;
   int          settings_applied;
   int          node_seen[4];

   room_occupancy_climate_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2000000;
      $display("Timed out with %0d results still expected.", pending_results.size());
      $display("FAIL room_occupancy_climate_controller_core");
      $finish;
   end

   function automatic rocc_pkg::req_word_type make_poll(input bit climate_ok, input int temp,
                                                        input bit range_ok, input int dist_cm,
                                                        input bit dark, input logic [31:0] now,
                                                        input bit light, input bit aux);
      rocc_pkg::req_word_type w;
      w.climate_ok   = climate_ok;
      w.temperature  = 12'(temp);
      w.range_ok     = range_ok;
      w.distance_cm  = 10'(dist_cm);
      w.is_dark      = dark;
      w.now_ms       = now;
      w.manual_light = light;
      w.manual_aux   = aux;
      return w;
   endfunction

   function automatic rocc_pkg::rsp_word_type make_result(input bit instant, input bit fault,
                                                          input logic [1:0] code,
                                                          input bit occ, input bit alert,
                                                          input logic [1:0] node,
                                                          input bit light, input bit aux,
                                                          input logic [31:0] stamp);
      rocc_pkg::rsp_word_type r;
      r.instant_occupied = instant;
      r.sensor_fault     = fault;
      r.fault_code       = code;
      r.occupied         = occ;
      r.temp_alert       = alert;
      r.node_state       = node;
      r.light_relay      = light;
      r.aux_relay        = aux;
      r.stamp_ms         = stamp;
      return r;
   endfunction

   // Advances the controller state by one poll and works out the result word.
   task automatic predict_poll(input rocc_pkg::req_word_type p,
                               output rocc_pkg::rsp_word_type r);
      logic        instant;
      logic        held;
      logic [1:0]  code;
      logic [31:0] since_ms;
      if (p.climate_ok) begin
         climate_fails = 8'd0;
      end else if (climate_fails != rocc_pkg::FAIL_COUNT_MAX) begin
         climate_fails = climate_fails + 8'd1;
      end
      if (p.range_ok) begin
         range_fails = 8'd0;
      end else if (range_fails != rocc_pkg::FAIL_COUNT_MAX) begin
         range_fails = range_fails + 8'd1;
      end
      code = rocc_pkg::FAULT_NONE;
      if (climate_fails >= cfg_fail_limit) code = code | rocc_pkg::FAULT_CLIMATE;
      if (range_fails >= cfg_fail_limit) code = code | rocc_pkg::FAULT_RANGE;

      // A near sighting restarts the vacancy hold; the time difference wraps.
      instant = p.range_ok && p.distance_cm != 10'd0 && p.distance_cm <= cfg_near_cm;
      if (instant) begin
         last_sighting_ms = p.now_ms;
         sighted = 1'b1;
      end
      since_ms = p.now_ms - last_sighting_ms;
      held = instant || (sighted && since_ms < cfg_hold_ms);

      // The latch only moves on a valid reading; setting wins over clearing.
      if (p.climate_ok) begin
         if (p.temperature >= cfg_hot_on) begin
            hot_latch = 1'b1;
         end else if (p.temperature <= cfg_hot_off) begin
            hot_latch = 1'b0;
         end
      end

      r = '0;
      r.instant_occupied = instant;
      r.sensor_fault     = code != rocc_pkg::FAULT_NONE;
      r.fault_code       = code;
      r.occupied         = held;
      r.temp_alert       = hot_latch;
      r.stamp_ms         = p.now_ms;
      if (code != rocc_pkg::FAULT_NONE) begin
         r.node_state = rocc_pkg::NODE_FAULT;
      end else begin
         case (cfg_mode)
            rocc_pkg::MODE_MANUAL: begin
               r.node_state  = rocc_pkg::NODE_MANUAL;
               r.light_relay = p.manual_light;
               r.aux_relay   = p.manual_aux;
            end
            rocc_pkg::MODE_AWAY: begin
               r.node_state = instant ? rocc_pkg::NODE_ALERT : rocc_pkg::NODE_MONITORING;
               r.aux_relay  = instant;
            end
            default: begin
               r.node_state  = hot_latch ? rocc_pkg::NODE_ALERT : rocc_pkg::NODE_MONITORING;
               r.light_relay = p.is_dark && held;
               r.aux_relay   = hot_latch;
            end
         endcase
      end
   endtask

   // Sender gaps: mostly none or short, now and then long, with calm stretches.
   function automatic int pick_gap();
      int roll;
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      if (sender_calm) return 0;
      roll = int'($urandom_range(0, 99));
      if (roll < 60) return 0;
      if (roll < 95) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   // Offers one poll and records its expected result once it is taken.
   task automatic send_poll(input rocc_pkg::req_word_type w, input bit typed,
                            input rocc_pkg::rsp_word_type typed_result);
      int                     gap;
      rocc_pkg::rsp_word_type predicted;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_poll(w, predicted);
      pending_results.push_back(typed ? typed_result : predicted);
      polls_sent++;
   endtask

   // Stops sending and waits until every expected word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Writes one register; bits above the register width carry noise.
   task automatic csr_write(input logic [rocc_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [31:0] value, input int width);
      logic [31:0] keep;
      logic [31:0] data;
      keep = (width >= 32) ? 32'hFFFF_FFFF : (32'd1 << width) - 32'd1;
      data = (value & keep) | ($urandom & ~keep);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         rocc_pkg::REG_FAIL_LIMIT:      cfg_fail_limit = data[7:0];
         rocc_pkg::REG_OCC_DISTANCE:    cfg_near_cm    = data[9:0];
         rocc_pkg::REG_VACANCY_TIMEOUT: cfg_hold_ms    = data;
         rocc_pkg::REG_ALERT_ON_TEMP:   cfg_hot_on     = data[11:0];
         rocc_pkg::REG_ALERT_OFF_TEMP:  cfg_hot_off    = data[11:0];
         rocc_pkg::REG_OP_MODE:         cfg_mode       = data[1:0];
         default: ;
      endcase
   endtask

   // Random poll: readings cluster around the thresholds, time mostly moves forward.
   task automatic make_random_poll(input phase_plan_type pl,
                                   output rocc_pkg::req_word_type w);
      int temp;
      int dist_cm;
      case ($urandom_range(0, 7))
         0:       temp = int'($urandom_range(0, 4095));
         1:       temp = temp_extremes[$urandom_range(0, 3)];
         2, 3:    temp = int'(cfg_hot_on) + int'($urandom_range(0, 6)) - 3;
         4, 5:    temp = int'(cfg_hot_off) + int'($urandom_range(0, 6)) - 3;
         default: temp = int'($urandom_range(0, 1650)) - 400;
      endcase
      case ($urandom_range(0, 5))
         0:       dist_cm = 0;
         1:       dist_cm = int'($urandom_range(0, 1023));
         2:       dist_cm = int'(cfg_near_cm) + int'($urandom_range(0, 2)) - 1;
         default: dist_cm = int'($urandom_range(0, int'(cfg_near_cm) * 3 / 2 + 1));
      endcase
      if ($urandom_range(0, 24) == 0) begin
         clock_ms = $urandom;
      end else begin
         clock_ms = clock_ms + $urandom_range(0, pl.step_max);
      end
      w = make_poll($urandom_range(0, 99) >= pl.climate_bad_pct, temp,
                    $urandom_range(0, 99) >= pl.range_bad_pct, dist_cm,
                    1'($urandom), clock_ms, 1'($urandom), 1'($urandom));
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         if (mismatches < 10) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         end
         mismatches++;
      end
   endtask

   // Result side: random stalls, mostly short, some long, with calm stretches.
   always @(posedge clock) begin
      int roll;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (ready_hold != 0) begin
         ready_hold--;
      end else begin
         if ($urandom_range(0, 79) == 0) ready_calm = !ready_calm;
         roll = int'($urandom_range(0, 99));
         if (ready_calm || roll < 65) begin
            rsp_ready <= 1'b1;
            ready_hold = int'($urandom_range(0, 3));
         end else if (roll < 95) begin
            rsp_ready <= 1'b0;
            ready_hold = int'($urandom_range(0, 2));
         end else begin
            rsp_ready <= 1'b0;
            ready_hold = int'($urandom_range(9, 39));
         end
      end
   end

   // Compare every accepted result word with the oldest expectation.
   always @(posedge clock) begin
      rocc_pkg::rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            if (mismatches < 10) begin
               $display("%0t: result word %0h with nothing expected", $time, rsp_word);
            end
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("instant_occupied", want.instant_occupied, rsp_word.instant_occupied);
            check_field("sensor_fault", want.sensor_fault, rsp_word.sensor_fault);
            check_field("fault_code", want.fault_code, rsp_word.fault_code);
            check_field("occupied", want.occupied, rsp_word.occupied);
            check_field("temp_alert", want.temp_alert, rsp_word.temp_alert);
            check_field("node_state", want.node_state, rsp_word.node_state);
            check_field("light_relay", want.light_relay, rsp_word.light_relay);
            check_field("aux_relay", want.aux_relay, rsp_word.aux_relay);
            check_field("stamp_ms", want.stamp_ms, rsp_word.stamp_ms);
            results_seen++;
            node_seen[rsp_word.node_state]++;
         end
      end
   end

   initial begin
      phase_plan_type         plan;
      rocc_pkg::req_word_type poll;
      int                     scripted;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      cfg_fail_limit   = rocc_pkg::RST_FAIL_LIMIT;
      cfg_near_cm      = rocc_pkg::RST_OCC_DISTANCE;
      cfg_hold_ms      = rocc_pkg::RST_VACANCY_TIMEOUT;
      cfg_hot_on       = rocc_pkg::RST_ALERT_ON_TEMP;
      cfg_hot_off      = rocc_pkg::RST_ALERT_OFF_TEMP;
      cfg_mode         = rocc_pkg::MODE_AUTO;
      climate_fails    = 8'd0;
      range_fails      = 8'd0;
      last_sighting_ms = 32'd0;
      sighted          = 1'b0;
      hot_latch        = 1'b0;
      clock_ms         = 32'd0;

      // Opening script under the reset settings: thresholds, distance edges,
      // the timeout edge, failure runs into both faults, time wrap, every mode.
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(1, 250, 1, 50, 1, 1000, 0, 0), 1'b1,
         make_result(1, 0, rocc_pkg::FAULT_NONE, 1, 0, rocc_pkg::NODE_MONITORING, 1, 0,
                     32'd1000)});
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(1, 300, 1, 0, 0, 2000, 0, 0), 1'b1,
         make_result(0, 0, rocc_pkg::FAULT_NONE, 1, 1, rocc_pkg::NODE_ALERT, 0, 1,
                     32'd2000)});
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(1, 281, 1, 100, 1, 3000, 0, 0),
                         1'b0, '0});
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(1, 280, 1, 101, 1, 32999, 0, 0),
                         1'b0, '0});
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(1, 1250, 1, 1023, 0, 33000, 0, 0),
                         1'b0, '0});
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(1, -400, 1, 1, 1, 33001, 0, 0),
                         1'b0, '0});
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(1, 2047, 1, 0, 0, 40000, 0, 0),
                         1'b0, '0});
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(1, -2048, 1, 0, 0, 40001, 0, 0),
                         1'b0, '0});
      // Climate failures with a hot reading that must not move the latch.
      for (int k = 0; k < 4; k++) begin
         script.push_back('{rocc_pkg::MODE_AUTO,
                            make_poll(0, 2047, 1, 0, 0, 50000 + k, 0, 0), 1'b0, '0});
      end
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(0, 2047, 1, 0, 0, 50004, 1, 1), 1'b1,
         make_result(0, 1, rocc_pkg::FAULT_CLIMATE, 1, 0, rocc_pkg::NODE_FAULT, 0, 0,
                     32'd50004)});
      // Both sensors failing until the range fault joins the climate fault.
      for (int k = 0; k < 4; k++) begin
         script.push_back('{rocc_pkg::MODE_AUTO,
                            make_poll(0, 0, 0, 50, 1, 60000 + k, 0, 0), 1'b0, '0});
      end
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(0, 0, 0, 50, 1, 60004, 1, 1), 1'b1,
         make_result(0, 1, rocc_pkg::FAULT_CLIMATE | rocc_pkg::FAULT_RANGE, 1, 0,
                     rocc_pkg::NODE_FAULT, 0, 0, 32'd60004)});
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(1, 0, 1, 50, 1, 32'hFFFF_FFF0, 0, 0),
                         1'b0, '0});
      script.push_back('{rocc_pkg::MODE_AUTO, make_poll(1, 0, 1, 0, 1, 32'h10, 0, 0),
                         1'b0, '0});
      script.push_back('{rocc_pkg::MODE_MANUAL, make_poll(1, 0, 1, 500, 0, 100, 1, 0),
                         1'b0, '0});
      script.push_back('{rocc_pkg::MODE_MANUAL, make_poll(1, 1250, 0, 50, 1, 200, 0, 1),
                         1'b0, '0});
      script.push_back('{rocc_pkg::MODE_AWAY, make_poll(1, 0, 1, 10, 0, 300, 1, 1),
                         1'b0, '0});
      script.push_back('{rocc_pkg::MODE_AWAY, make_poll(1, 0, 1, 0, 1, 400, 0, 0),
                         1'b0, '0});
      script.push_back('{MODE_SPARE, make_poll(1, 1250, 1, 0, 1, 500, 1, 1), 1'b0, '0});

      // Fixed phases hold the register extremes; a fail limit of zero faults always,
      // and a stuck climate sensor drives its counter into saturation.
      plans.push_back('{8'd0, 10'd100, 32'd30000, 12'sd300, 12'sd280, rocc_pkg::MODE_AUTO,
                        30, 10, 10, 5000});
      plans.push_back('{8'd3, 10'd1023, 32'd0, 12'sh7FF, 12'sh800, rocc_pkg::MODE_AWAY,
                        60, 30, 30, 100});
      plans.push_back('{8'd255, 10'd0, 32'hFFFF_FFFF, -12'sd400, 12'sd1250,
                        rocc_pkg::MODE_MANUAL, 50, 20, 20, 50000});
      plans.push_back('{8'd255, 10'd200, 32'd5000, 12'sd250, 12'sd200, rocc_pkg::MODE_AUTO,
                        270, 100, 5, 2000});
      for (int k = 0; k < 4; k++) begin
         plan.fail_limit      = (k == 0) ? 8'd1 : 8'($urandom_range(1, 8));
         plan.near_cm         = 10'($urandom_range(0, 1023));
         plan.hold_ms         = $urandom_range(0, 20000);
         plan.hot_on          = 12'(int'($urandom_range(0, 1650)) - 400);
         plan.hot_off         = 12'(int'($urandom_range(0, 1650)) - 400);
         plan.mode            = (k == 0) ? MODE_SPARE : 2'($urandom_range(0, 3));
         plan.polls           = (k == 0) ? 50 : 45;
         plan.climate_bad_pct = 10;
         plan.range_bad_pct   = 10;
         plan.step_max        = int'(plan.hold_ms / 3) + 1;
         plans.push_back(plan);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Scripted part; a mode change waits for the block to go idle first.
      foreach (script[i]) begin
         if (script[i].mode != cfg_mode) begin
            drain_results();
            csr_write(rocc_pkg::REG_OP_MODE, 32'(script[i].mode), MODE_BITS);
            settings_applied++;
         end
         send_poll(script[i].poll, script[i].typed, script[i].result);
      end
      scripted = polls_sent;

      // Random phases, each under a fresh full set of registers.
      foreach (plans[p]) begin
         drain_results();
         csr_write(rocc_pkg::REG_FAIL_LIMIT, 32'(plans[p].fail_limit), FAIL_LIMIT_BITS);
         csr_write(rocc_pkg::REG_OCC_DISTANCE, 32'(plans[p].near_cm), DISTANCE_BITS);
         csr_write(rocc_pkg::REG_VACANCY_TIMEOUT, plans[p].hold_ms, TIMEOUT_BITS);
         csr_write(rocc_pkg::REG_ALERT_ON_TEMP, 32'(plans[p].hot_on), TEMP_BITS);
         csr_write(rocc_pkg::REG_ALERT_OFF_TEMP, 32'(plans[p].hot_off), TEMP_BITS);
         csr_write(rocc_pkg::REG_OP_MODE, 32'(plans[p].mode), MODE_BITS);
         settings_applied++;
         clock_ms = $urandom;
         repeat (plans[p].polls) begin
            make_random_poll(plans[p], poll);
            send_poll(poll, 1'b0, '0);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);

      $display("Sent %0d polls (%0d scripted) under %0d register settings;",
               polls_sent, scripted, settings_applied);
      $display("%0d results, %0d mismatches.", results_seen, mismatches);
      $display("Results by node state: monitoring %0d, manual %0d, alert %0d, fault %0d.",
               node_seen[rocc_pkg::NODE_MONITORING], node_seen[rocc_pkg::NODE_MANUAL],
               node_seen[rocc_pkg::NODE_ALERT], node_seen[rocc_pkg::NODE_FAULT]);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS room_occupancy_climate_controller_core");
      end else begin
         $display("FAIL room_occupancy_climate_controller_core");
      end
      $finish;
   end

endmodule

// ===== room_occupancy_climate_controller_core.f =====
hw/rtl/rocc_pkg.sv
hw/rtl/room_occupancy_climate_controller_core.sv
hw/rtl/rocc_checker.sv
sim/room_occupancy_climate_controller_core_tb.sv
